// File: hw/rtl/sfbr_pkg.sv
// ----------------------------------------------------------------------------
// sfbr_pkg
// Types, codes and constants of the sync framed block receiver.
// ----------------------------------------------------------------------------
package sfbr_pkg;

    localparam int BLOCK_BYTES_DEF = 256;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hC3;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hA9;
    localparam logic [7:0] STOP_MARGIN_RST = 8'd10;

    localparam logic [6:0] TGT_MASK = 7'h7F;
    localparam logic [6:0] TGT_I2C  = 7'h32;
    localparam logic [6:0] TGT_CAN  = 7'h34;

    typedef enum logic [1:0] {
        MODE_RX   = 2'd0,
        MODE_PROC = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EP_NONE = 2'd0,
        EP_I2C  = 2'd1,
        EP_CAN  = 2'd2
    } endpoint_t;

    typedef enum logic [1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_STOP_MARGIN = 2'd2
    } cfg_idx_t;

    typedef enum logic [5:0] {
        PH_SYNC1   = 6'b000001,
        PH_SYNC2   = 6'b000010,
        PH_VERSION = 6'b000100,
        PH_LENGTH  = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_CHECK   = 6'b100000
    } phase_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } item_t;

    typedef struct packed {
        logic       can_receive;
        logic       frame_done;
        logic       block_ready;
        logic [6:0] msg_dest;
        logic       msg_dir;
        logic [7:0] msg_id;
        endpoint_t  endpoint;
        logic [8:0] payload_start;
        logic [7:0] payload_len;
        logic       block_released;
        logic [7:0] read_data;
        logic [7:0] held_length;
    } result_t;

    typedef struct packed {
        cfg_idx_t   index;
        logic [7:0] value;
    } cfg_t;

endpackage

// File: hw/rtl/sfbr_stream_if.sv
// ----------------------------------------------------------------------------
// sfbr_stream_if
// Valid/ready channel carrying one beat of a typed payload.
// ----------------------------------------------------------------------------
interface sfbr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sfbr_ram.sv
// ----------------------------------------------------------------------------
// sfbr_ram
// Byte memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sfbr_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [7:0]    rdata_a,
    output logic [7:0]    rdata_b
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: hw/rtl/sync_framed_block_receiver_unit.sv
// ----------------------------------------------------------------------------
// sync_framed_block_receiver_unit
// Framed byte receiver with ping-pong banks and a sub-message parser.
//
//   channel  dir  payload   beat
//   item     in   item_t    line byte, process step or held byte read
//   result   out  result_t  one status beat per item
//   cfg      in   cfg_t     register write, always ready
//
// one item per cycle while the result is not stalled; an accepted item waits in
// the read stage during the memory read, then its status goes to the result register
// bytes are interleaved over an even and an odd memory, each with two read
// ports, so the three header bytes of a sub-message come in one read
// a per-bank fill mark makes never written bytes read as zero: no clearing pass
// a stalled result holds one item in the read stage, then input ready drops
// ----------------------------------------------------------------------------
module sync_framed_block_receiver_unit
    import sfbr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sfbr_stream_if.sink   item,
    sfbr_stream_if.source result,
    sfbr_stream_if.sink   cfg
);

    localparam int HDEPTH = (BLOCK_BYTES + 1) / 2;
    localparam int DEPTH  = 2 * HDEPTH;
    localparam int AW     = $clog2(DEPTH);
    localparam logic [8:0] BLOCK_LIMIT = 9'(BLOCK_BYTES);

    function automatic logic [AW-1:0] ram_addr(input logic bank, input logic [9:0] pos);
        logic [AW-1:0] base;
        base = bank ? AW'(HDEPTH) : '0;
        return AW'(base + AW'(pos[9:1]));
    endfunction

    logic [7:0] sync_first_reg, sync_second_reg, stop_margin_reg;

    phase_t     phase_reg, phase_next, step_phase;
    logic       recv_bank_reg, recv_bank_next, step_recv;
    logic [7:0] len0_reg, len0_next, step_len0;
    logic [7:0] len1_reg, len1_next, step_len1;
    logic [7:0] count_reg, count_next, step_count;
    logic       held_reg, held_next, step_held;
    logic [8:0] pidx_reg, pidx_next, step_pidx;
    logic [8:0] hw0_reg, hw0_next, step_hw0;
    logic [8:0] hw1_reg, hw1_next, step_hw1;

    logic       s1_valid_reg, s1_valid_next;
    mode_t      s1_mode_reg;
    logic [7:0] s1_rx_reg;
    logic [8:0] s1_pos_reg;

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, res, res_stat;

    logic       accept, retire, rd_en, wr_en;
    logic [8:0] issue_pos;
    logic [9:0] iq0, iq1, iq2, q0, q1, q2;
    logic [AW-1:0] addr0_a, addr1_a, addr_b, waddr;
    logic [7:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic [7:0] d0, d1, d2;
    logic       held_bank, issue_bank;
    logic [8:0] hw_held, cnt_ext;
    logic [7:0] cnt_inc, len_recv, blen, len_recv_n;
    logic [8:0] new_pidx, left;

    // channel handshakes
    assign retire       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready   = !s1_valid_reg || retire;
    assign accept       = item.valid && item.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // read data of the item in the read stage, masked by the fill mark
    assign held_bank = ~recv_bank_reg;
    assign hw_held   = held_bank ? hw1_reg : hw0_reg;
    assign q0 = {1'b0, s1_pos_reg};
    assign q1 = q0 + 10'd1;
    assign q2 = q0 + 10'd2;
    assign d0 = (q0 < {1'b0, hw_held}) ? (q0[0] ? rd1_a : rd0_a) : 8'd0;
    assign d1 = (q1 < {1'b0, hw_held}) ? (q0[0] ? rd0_a : rd1_a) : 8'd0;
    assign d2 = (q2 < {1'b0, hw_held}) ? (q0[0] ? rd1_b : rd0_b) : 8'd0;

    assign cnt_inc  = count_reg + 8'd1;
    assign cnt_ext  = {1'b0, count_reg} + 9'd1;
    assign len_recv = recv_bank_reg ? len1_reg : len0_reg;
    assign blen     = held_bank ? len1_reg : len0_reg;
    assign new_pidx = (d0 == 8'd0) ? {1'b0, blen} : 9'(pidx_reg + {1'b0, d0});

    always_comb
    begin
        step_phase = phase_reg;
        step_recv  = recv_bank_reg;
        step_len0  = len0_reg;
        step_len1  = len1_reg;
        step_count = count_reg;
        step_held  = held_reg;
        step_pidx  = pidx_reg;
        step_hw0   = hw0_reg;
        step_hw1   = hw1_reg;
        wr_en      = 1'b0;
        res        = '0;
        unique case (s1_mode_reg)
            MODE_RX:
            begin
                unique case (phase_reg)
                    PH_SYNC1:
                    begin
                        if (s1_rx_reg == sync_first_reg)
                        begin
                            step_phase = PH_SYNC2;
                        end
                    end
                    PH_SYNC2:
                    begin
                        step_phase = (s1_rx_reg == sync_second_reg) ? PH_VERSION : PH_SYNC1;
                    end
                    PH_VERSION:
                    begin
                        step_phase = PH_LENGTH;
                    end
                    PH_LENGTH:
                    begin
                        if (recv_bank_reg)
                        begin
                            step_len1 = s1_rx_reg;
                        end
                        else
                        begin
                            step_len0 = s1_rx_reg;
                        end
                        step_count = 8'd0;
                        step_phase = (s1_rx_reg == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if ({1'b0, count_reg} < BLOCK_LIMIT)
                        begin
                            wr_en = 1'b1;
                            if (recv_bank_reg && cnt_ext > hw1_reg)
                            begin
                                step_hw1 = cnt_ext;
                            end
                            if (!recv_bank_reg && cnt_ext > hw0_reg)
                            begin
                                step_hw0 = cnt_ext;
                            end
                        end
                        step_count = cnt_inc;
                        if (cnt_inc == len_recv)
                        begin
                            step_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        step_recv      = ~recv_bank_reg;
                        step_held      = 1'b1;
                        res.frame_done = 1'b1;
                        step_phase     = PH_SYNC1;
                    end
                    default:
                    begin
                        step_phase = PH_SYNC1;
                    end
                endcase
            end
            MODE_PROC:
            begin
                if (held_reg)
                begin
                    res.msg_dest = d1[6:0] & TGT_MASK;
                    res.msg_dir  = d1[7];
                    res.msg_id   = d2;
                    if (d0 != 8'd0)
                    begin
                        if (d1[6:0] == TGT_I2C)
                        begin
                            res.endpoint = EP_I2C;
                        end
                        else if (d1[6:0] == TGT_CAN)
                        begin
                            res.endpoint = EP_CAN;
                        end
                        res.payload_start = 9'(pidx_reg + 9'd3);
                        res.payload_len   = d0 - 8'd3;
                    end
                    step_pidx = new_pidx;
                    if (new_pidx >= {1'b0, blen})
                    begin
                        step_held          = 1'b0;
                        step_pidx          = 9'd0;
                        res.block_released = 1'b1;
                    end
                end
            end
            MODE_READ:
            begin
                res.read_data = d0;
            end
            MODE_NONE:
            begin
            end
        endcase
    end

    assign phase_next     = retire ? step_phase : phase_reg;
    assign recv_bank_next = retire ? step_recv  : recv_bank_reg;
    assign len0_next      = retire ? step_len0  : len0_reg;
    assign len1_next      = retire ? step_len1  : len1_reg;
    assign count_next     = retire ? step_count : count_reg;
    assign held_next      = retire ? step_held  : held_reg;
    assign pidx_next      = retire ? step_pidx  : pidx_reg;
    assign hw0_next       = retire ? step_hw0   : hw0_reg;
    assign hw1_next       = retire ? step_hw1   : hw1_reg;

    // status after the step
    assign len_recv_n = step_recv ? step_len1 : step_len0;
    assign left       = {1'b0, len_recv_n} - {1'b0, step_count};

    always_comb
    begin
        res_stat             = res;
        res_stat.can_receive = !step_held || step_phase != PH_DATA
                               || !($signed(left) < $signed({1'b0, stop_margin_reg}));
        res_stat.block_ready = step_held;
        res_stat.held_length = step_recv ? step_len0 : step_len1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (retire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (retire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // read issue for the incoming item, from the state after the retiring one
    assign issue_bank = ~recv_bank_next;
    assign issue_pos  = (item.data.mode == MODE_READ) ? {1'b0, item.data.read_index} : pidx_next;
    assign rd_en      = accept && (item.data.mode == MODE_PROC || item.data.mode == MODE_READ);
    assign iq0     = {1'b0, issue_pos};
    assign iq1     = iq0 + 10'd1;
    assign iq2     = iq0 + 10'd2;
    assign addr0_a = iq0[0] ? ram_addr(issue_bank, iq1) : ram_addr(issue_bank, iq0);
    assign addr1_a = iq0[0] ? ram_addr(issue_bank, iq0) : ram_addr(issue_bank, iq1);
    assign addr_b  = ram_addr(issue_bank, iq2);
    assign waddr   = ram_addr(recv_bank_reg, {2'b00, count_reg});

    sfbr_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_even_ram (
        .clk     (clk),
        .we      (retire && wr_en && !count_reg[0]),
        .waddr   (waddr),
        .wdata   (s1_rx_reg),
        .re      (rd_en),
        .raddr_a (addr0_a),
        .raddr_b (addr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    sfbr_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_odd_ram (
        .clk     (clk),
        .we      (retire && wr_en && count_reg[0]),
        .waddr   (waddr),
        .wdata   (s1_rx_reg),
        .re      (rd_en),
        .raddr_a (addr1_a),
        .raddr_b (addr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            stop_margin_reg <= STOP_MARGIN_RST;
            phase_reg       <= PH_SYNC1;
            recv_bank_reg   <= 1'b0;
            len0_reg        <= 8'd0;
            len1_reg        <= 8'd0;
            count_reg       <= 8'd0;
            held_reg        <= 1'b0;
            pidx_reg        <= 9'd0;
            hw0_reg         <= 9'd0;
            hw1_reg         <= 9'd0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.data.index)
                    CFG_SYNC_FIRST:  sync_first_reg  <= cfg.data.value;
                    CFG_SYNC_SECOND: sync_second_reg <= cfg.data.value;
                    CFG_STOP_MARGIN: stop_margin_reg <= cfg.data.value;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg     <= phase_next;
            recv_bank_reg <= recv_bank_next;
            len0_reg      <= len0_next;
            len1_reg      <= len1_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
            pidx_reg      <= pidx_next;
            hw0_reg       <= hw0_next;
            hw1_reg       <= hw1_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= item.data.mode;
            s1_rx_reg   <= item.data.rx_byte;
            s1_pos_reg  <= issue_pos;
        end
        if (retire)
        begin
            out_reg <= res_stat;
        end
    end

`ifndef SYNTH
    a_release_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.block_released |-> !result.data.block_ready)
        else $error("released block still reported ready");

    a_frame_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.frame_done |-> result.data.block_ready)
        else $error("finished frame not reported ready");

    a_fill_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw0_reg <= BLOCK_LIMIT && hw1_reg <= BLOCK_LIMIT)
        else $error("fill mark beyond bank size");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !result.ready |-> !item.ready)
        else $error("input taken while read stage is stalled");
`endif

endmodule

// File: dv/tb_sync_framed_block_receiver_unit.sv
// ----------------------------------------------------------------------------
// tb_sync_framed_block_receiver_unit
// Self-checking bench for the sync framed block receiver. A short stimulus
// table is followed by constrained-random frame traffic: well-formed frames
// packed with sub-messages, broken frames, line noise, process steps and
// held byte reads. Registers are reprogrammed between phases. An in-bench
// predictor tracks framing, the ping-pong banks and the sub-message parser,
// and every status beat is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_sync_framed_block_receiver_unit
    import sfbr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLK        = BLOCK_BYTES_DEF;
    localparam int WDOG_LIMIT = 4000;
    localparam int NUM_PHASES = 6;
    localparam int PRESS_PH   = 4;
    localparam int PHASE_LEN  = 330;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n;

    sfbr_stream_if #(.T(item_t))   item_if ();
    sfbr_stream_if #(.T(result_t)) status_if ();
    sfbr_stream_if #(.T(cfg_t))    cfg_if ();

    sync_framed_block_receiver_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (status_if),
        .cfg    (cfg_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [7:0] sync_a, sync_b, margin;
    phase_t     cur_phase;
    logic [7:0] bank_mem [0:2*BLK-1];
    logic       rx_bank;
    logic [7:0] bank_len [0:1];
    logic [7:0] byte_cnt;
    logic       held_valid;
    logic [8:0] parse_pos;

    result_t pending_status [$];
    vec_t    dir_rows [$];

    int gap_pct, stall_pct, mix_pct;
    int hold_off_len;
    int items_sent, line_bytes, reg_writes, holds_done;
    int frames_seen, releases_seen, results_seen;
    int mismatches;
    int quiet_cycles;

    result_t    chk_want;
    logic [11:0] chk_diff;

    function automatic logic [7:0] bank_byte(logic bank, int pos);
        if (pos >= BLK)
            return 8'h00;
        return bank_mem[{bank, 8'(pos)}];
    endfunction

    function automatic logic flow_open();
        int left;
        if (!held_valid)
            return 1'b1;
        if (cur_phase == PH_DATA)
        begin
            left = int'(bank_len[rx_bank]) - int'(byte_cnt);
            if (left < int'(margin))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic result_t parse_step(item_t it);
        result_t    r;
        logic       hb;
        logic [7:0] sub_len, tb, blen;
        r  = '0;
        hb = ~rx_bank;
        case (it.mode)
            MODE_RX:
            begin
                case (cur_phase)
                    PH_SYNC1:
                        if (it.rx_byte == sync_a)
                            cur_phase = PH_SYNC2;
                    PH_SYNC2:
                        cur_phase = (it.rx_byte == sync_b) ? PH_VERSION : PH_SYNC1;
                    PH_VERSION:
                        cur_phase = PH_LENGTH;
                    PH_LENGTH:
                    begin
                        bank_len[rx_bank] = it.rx_byte;
                        byte_cnt = 8'd0;
                        cur_phase = (it.rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        bank_mem[{rx_bank, byte_cnt}] = it.rx_byte;
                        byte_cnt = byte_cnt + 8'd1;
                        if (byte_cnt == bank_len[rx_bank])
                            cur_phase = PH_CHECK;
                    end
                    PH_CHECK:
                    begin
                        rx_bank = ~rx_bank;
                        held_valid = 1'b1;
                        r.frame_done = 1'b1;
                        cur_phase = PH_SYNC1;
                    end
                    default:
                        cur_phase = PH_SYNC1;
                endcase
            end
            MODE_PROC:
            begin
                if (held_valid)
                begin
                    sub_len = bank_byte(hb, int'(parse_pos));
                    tb      = bank_byte(hb, int'(parse_pos) + 1);
                    blen    = bank_len[hb];
                    r.msg_dest = tb[6:0];
                    r.msg_dir  = tb[7];
                    r.msg_id   = bank_byte(hb, int'(parse_pos) + 2);
                    if (sub_len == 8'd0)
                        parse_pos = {1'b0, blen};
                    else
                    begin
                        if (tb[6:0] == TGT_I2C)
                            r.endpoint = EP_I2C;
                        else if (tb[6:0] == TGT_CAN)
                            r.endpoint = EP_CAN;
                        r.payload_start = parse_pos + 9'd3;
                        r.payload_len   = sub_len - 8'd3;
                        parse_pos = parse_pos + {1'b0, sub_len};
                    end
                    if (parse_pos >= {1'b0, blen})
                    begin
                        held_valid = 1'b0;
                        parse_pos = 9'd0;
                        r.block_released = 1'b1;
                    end
                end
            end
            MODE_READ:
                r.read_data = bank_byte(hb, int'(it.read_index));
            default:
                ;
        endcase
        r.can_receive = flow_open();
        r.block_ready = held_valid;
        r.held_length = bank_len[~rx_bank];
        return r;
    endfunction

    function automatic logic [11:0] field_diff(result_t a, result_t b);
        return {a.can_receive !== b.can_receive, a.frame_done !== b.frame_done,
                a.block_ready !== b.block_ready, a.msg_dest !== b.msg_dest,
                a.msg_dir !== b.msg_dir, a.msg_id !== b.msg_id,
                a.endpoint !== b.endpoint, a.payload_start !== b.payload_start,
                a.payload_len !== b.payload_len, a.block_released !== b.block_released,
                a.read_data !== b.read_data, a.held_length !== b.held_length};
    endfunction

    function automatic item_t pack_item(mode_t m, logic [7:0] rx, logic [7:0] ri);
        item_t it;
        it.mode = m;
        it.rx_byte = rx;
        it.read_index = ri;
        return it;
    endfunction

    function automatic result_t status_word(logic can, logic done, logic rdy, logic rel);
        result_t r;
        r = '0;
        r.can_receive = can;
        r.frame_done = done;
        r.block_ready = rdy;
        r.block_released = rel;
        return r;
    endfunction

    function automatic vec_t row(mode_t m, logic [7:0] rx, logic [7:0] ri, bit typed,
                                 result_t want);
        vec_t v;
        v.it = pack_item(m, rx, ri);
        v.typed = typed;
        v.want = want;
        return v;
    endfunction

    task automatic send_item(item_t it, bit typed, result_t want);
        result_t pred;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do @(posedge clk); while (!item_if.ready);
        pred = parse_step(it);
        pending_status.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic send_side();
        int    pick;
        mode_t m;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            m = MODE_PROC;
        else if (pick < 85)
            m = MODE_READ;
        else
            m = MODE_NONE;
        send_item(pack_item(m, 8'($urandom), 8'($urandom)), 1'b0, '0);
    endtask

    task automatic send_line(logic [7:0] b);
        if ($urandom_range(0, 99) < mix_pct)
            send_side();
        send_item(pack_item(MODE_RX, b, 8'($urandom)), 1'b0, '0);
        line_bytes++;
    endtask

    task automatic send_frame();
        logic [7:0] body [$];
        int         flen, room, sub, pick;
        logic [7:0] tgt;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            flen = 0;
        else if (pick < 90)
            flen = $urandom_range(3, 40);
        else if (pick < 98)
            flen = $urandom_range(41, 128);
        else
            flen = 255;
        while (body.size() < flen)
        begin
            room = flen - body.size();
            if (room < 3 || $urandom_range(0, 99) < 8)
                body.push_back(8'($urandom));
            else
            begin
                sub = $urandom_range(3, room < 24 ? room : 24);
                if ($urandom_range(0, 99) < 4)
                    sub = 0;
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    tgt = {1'b0, TGT_I2C};
                else if (pick == 1)
                    tgt = {1'b0, TGT_CAN};
                else
                    tgt = {1'b0, 7'($urandom)};
                tgt[7] = 1'($urandom);
                body.push_back(8'(sub));
                body.push_back(tgt);
                body.push_back(8'($urandom));
                repeat (sub > 3 ? sub - 3 : 0) body.push_back(8'($urandom));
            end
        end
        send_line(sync_a);
        send_line(sync_b);
        send_line(8'($urandom));
        send_line(8'(flen));
        foreach (body[i])
            send_line(body[i]);
        send_line(8'($urandom));
        repeat ($urandom_range(0, 6)) send_side();
    endtask

    task automatic send_traffic();
        int         pick;
        logic [7:0] bad;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            send_frame();
        else if (pick < 82)
            repeat ($urandom_range(1, 6)) send_line(8'($urandom));
        else if (pick < 90)
        begin
            // second sync byte off by one bit
            bad = sync_b ^ (8'd1 << $urandom_range(0, 7));
            send_line(sync_a);
            send_line(bad);
        end
        else if (pick < 94)
        begin
            // header then a short body that may stop before the given length
            send_line(sync_a);
            send_line(sync_b);
            send_line(8'($urandom));
            send_line(8'($urandom_range(1, 60)));
            repeat ($urandom_range(0, 5)) send_line(8'($urandom));
        end
        else
            repeat ($urandom_range(1, 8)) send_side();
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        cfg_if.valid      <= 1'b1;
        cfg_if.data.index <= idx;
        cfg_if.data.value <= val;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            CFG_SYNC_FIRST:  sync_a = val;
            CFG_SYNC_SECOND: sync_b = val;
            CFG_STOP_MARGIN: margin = val;
            default:         ;
        endcase
        reg_writes++;
    endtask

    task automatic set_regs(logic [7:0] s1, logic [7:0] s2, logic [7:0] m);
        write_reg(CFG_SYNC_FIRST, s1);
        write_reg(CFG_SYNC_SECOND, s2);
        write_reg(CFG_STOP_MARGIN, m);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // status sink with random stalls and one long hold-off
    initial
    begin
        status_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_len > 0)
            begin
                status_if.ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                holds_done++;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                status_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                status_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && status_if.valid && status_if.ready)
        begin
            results_seen++;
            frames_seen   += status_if.data.frame_done;
            releases_seen += status_if.data.block_released;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status beat at %0t: %h", $time, status_if.data);
            end
            else
            begin
                chk_want = pending_status.pop_front();
                chk_diff = field_diff(chk_want, status_if.data);
                if (chk_diff != 12'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t fields %03h exp %h got %h",
                                 $time, chk_diff, chk_want, status_if.data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_if.valid && item_if.ready) ||
            (status_if.valid && status_if.ready) || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", WDOG_LIMIT);
            $display("sync_framed_block_receiver_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        int      phase_end;
        result_t ok_idle;
        rst_n <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.data  <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        quiet_cycles = 0;
        hold_off_len = 0;
        gap_pct = 0;
        stall_pct = 0;
        mix_pct = 0;
        sync_a = SYNC_FIRST_RST;
        sync_b = SYNC_SECOND_RST;
        margin = STOP_MARGIN_RST;
        cur_phase = PH_SYNC1;
        foreach (bank_mem[i])
            bank_mem[i] = 8'h00;
        rx_bank = 1'b0;
        bank_len[0] = 8'h00;
        bank_len[1] = 8'h00;
        byte_cnt = 8'h00;
        held_valid = 1'b0;
        parse_pos = 9'd0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        ok_idle = status_word(1'b1, 1'b0, 1'b0, 1'b0);
        // idle, process and read with nothing held
        dir_rows.push_back(row(MODE_NONE, 8'hFF, 8'hFF, 1'b1, ok_idle));
        dir_rows.push_back(row(MODE_PROC, 8'h00, 8'h00, 1'b1, ok_idle));
        dir_rows.push_back(row(MODE_READ, 8'h00, 8'hFF, 1'b1, ok_idle));
        // wrong second sync, then a stray second sync
        dir_rows.push_back(row(MODE_RX, 8'hC3, 8'h00, 1'b1, ok_idle));
        dir_rows.push_back(row(MODE_RX, 8'hC3, 8'h00, 1'b1, ok_idle));
        dir_rows.push_back(row(MODE_RX, 8'hA9, 8'h00, 1'b1, ok_idle));
        // zero length frame
        dir_rows.push_back(row(MODE_RX, 8'hC3, 8'h00, 1'b1, ok_idle));
        dir_rows.push_back(row(MODE_RX, 8'hA9, 8'h00, 1'b1, ok_idle));
        dir_rows.push_back(row(MODE_RX, 8'hFF, 8'h00, 1'b1, ok_idle));
        dir_rows.push_back(row(MODE_RX, 8'h00, 8'h00, 1'b1, ok_idle));
        dir_rows.push_back(row(MODE_RX, 8'h5A, 8'h00, 1'b1,
                               status_word(1'b1, 1'b1, 1'b1, 1'b0)));
        // zero sub-message length abandons the block
        dir_rows.push_back(row(MODE_PROC, 8'h00, 8'h00, 1'b1,
                               status_word(1'b1, 1'b0, 1'b0, 1'b1)));
        // two sub-messages, i2c with direction bit then can
        dir_rows.push_back(row(MODE_RX, 8'hC3, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'hA9, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'h01, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'h06, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'h03, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'hB2, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'h11, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'h03, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'h34, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'hFF, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_RX, 8'h00, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_PROC, 8'h00, 8'h00, 1'b0, '0));
        dir_rows.push_back(row(MODE_PROC, 8'h00, 8'h00, 1'b0, '0));
        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0:       set_regs(SYNC_FIRST_RST, SYNC_SECOND_RST, STOP_MARGIN_RST);
                1:       set_regs(8'h00, 8'hFF, 8'h00);
                2:       set_regs(8'hFF, 8'h00, 8'hFF);
                3:       set_regs(8'($urandom), 8'($urandom), 8'($urandom));
                PRESS_PH: set_regs(SYNC_FIRST_RST, SYNC_SECOND_RST,
                                   8'($urandom_range(0, 40)));
                default: set_regs(8'($urandom), 8'($urandom), STOP_MARGIN_RST);
            endcase
            mix_pct = $urandom_range(0, 15);
            if (ph == NUM_PHASES - 1)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else if (ph == PRESS_PH)
            begin
                gap_pct = 0;
                stall_pct = 5;
                hold_off_len = HOLD_LEN;
            end
            else
            begin
                gap_pct = 12 * $urandom_range(0, 2);
                stall_pct = 12 * $urandom_range(0, 2);
            end
            phase_end = items_sent + PHASE_LEN;
            while (items_sent < phase_end)
                send_traffic();
        end
        settle();
        repeat (6) @(posedge clk);

        $display("ran %0d items (%0d line bytes), %0d status beats, %0d register writes",
                 items_sent, line_bytes, results_seen, reg_writes);
        $display("saw %0d frames end, %0d blocks released, %0d long output hold-offs",
                 frames_seen, releases_seen, holds_done);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("sync_framed_block_receiver_unit verification clean");
        else
            $display("sync_framed_block_receiver_unit verification failed");
        $finish;
    end

endmodule
